// ===== hdl/bqpost_pkg.sv =====
// package for the boolean query infix-to-postfix converter
// holds token and stack codes, sizes and the queued token type; no dependencies
`default_nettype none

package bqpost_pkg;

    // operator stack size and derived widths
    localparam int STACK_DEPTH = 16;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

    // token queue between front and back (power of two)
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam int WORD_W = 16;

    // incoming operation codes
    localparam logic [2:0] OP_WORD  = 3'd0;
    localparam logic [2:0] OP_OPEN  = 3'd1;
    localparam logic [2:0] OP_CLOSE = 3'd2;
    localparam logic [2:0] OP_OR    = 3'd3;
    localparam logic [2:0] OP_AND   = 3'd4;
    localparam logic [2:0] OP_NOT   = 3'd5;
    localparam logic [2:0] OP_END   = 3'd6;

    // stack entry codes, also the postfix item kinds; operator code is its precedence
    localparam logic [1:0] CODE_OPEN = 2'd0;
    localparam logic [1:0] CODE_WORD = 2'd0;
    localparam logic [1:0] CODE_OR   = 2'd1;
    localparam logic [1:0] CODE_AND  = 2'd2;
    localparam logic [1:0] CODE_NOT  = 2'd3;

    // token classes after decode
    localparam logic [2:0] CLS_WORD  = 3'd0;
    localparam logic [2:0] CLS_OPEN  = 3'd1;
    localparam logic [2:0] CLS_CLOSE = 3'd2;
    localparam logic [2:0] CLS_OPER  = 3'd3;
    localparam logic [2:0] CLS_END   = 3'd4;
    localparam logic [2:0] CLS_NONE  = 3'd5;

    // decoded token as it sits in the queue
    typedef struct packed {
        logic [2:0]        cls;
        logic [1:0]        code;
        logic [WORD_W-1:0] word;
    } t_tok;

endpackage

`default_nettype wire

// ===== hdl/bqpost_front.sv =====
// front end: accepts input items, decodes the token kind and queues them
// depends on bqpost_pkg
`default_nettype none

module bqpost_front (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_stall,
    input  wire logic [2:0]                i_operation,
    input  wire logic [15:0]               i_word_id,
    output logic                           o_q_valid,
    output bqpost_pkg::t_tok               o_q_tok,
    input  wire logic                      i_q_pop
);

    bqpost_pkg::t_tok                        r_mem [bqpost_pkg::QUEUE_DEPTH];
    logic [bqpost_pkg::QPTR_W-1:0]           r_wr_ptr, n_wr_ptr;
    logic [bqpost_pkg::QPTR_W-1:0]           r_rd_ptr, n_rd_ptr;
    logic [bqpost_pkg::QCNT_W-1:0]           r_cnt, n_cnt;
    bqpost_pkg::t_tok                        dec_tok;
    logic                                    push;
    logic                                    pop;

    // token decode
    always_comb begin
        dec_tok.word = i_word_id;
        dec_tok.code = bqpost_pkg::CODE_OPEN;
        unique case (i_operation)
            bqpost_pkg::OP_WORD: begin
                dec_tok.cls = bqpost_pkg::CLS_WORD;
            end
            bqpost_pkg::OP_OPEN: begin
                dec_tok.cls = bqpost_pkg::CLS_OPEN;
            end
            bqpost_pkg::OP_CLOSE: begin
                dec_tok.cls = bqpost_pkg::CLS_CLOSE;
            end
            bqpost_pkg::OP_OR: begin
                dec_tok.cls  = bqpost_pkg::CLS_OPER;
                dec_tok.code = bqpost_pkg::CODE_OR;
            end
            bqpost_pkg::OP_AND: begin
                dec_tok.cls  = bqpost_pkg::CLS_OPER;
                dec_tok.code = bqpost_pkg::CODE_AND;
            end
            bqpost_pkg::OP_NOT: begin
                dec_tok.cls  = bqpost_pkg::CLS_OPER;
                dec_tok.code = bqpost_pkg::CODE_NOT;
            end
            bqpost_pkg::OP_END: begin
                dec_tok.cls = bqpost_pkg::CLS_END;
            end
            default: begin
                dec_tok.cls = bqpost_pkg::CLS_NONE;
            end
        endcase
    end

    // queue control
    assign o_stall   = (r_cnt == bqpost_pkg::QCNT_W'(bqpost_pkg::QUEUE_DEPTH));
    assign o_q_valid = (r_cnt != '0);
    assign o_q_tok   = r_mem[r_rd_ptr];
    assign push      = i_valid && !o_stall;
    assign pop       = i_q_pop && o_q_valid;

    always_comb begin
        n_wr_ptr = push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_cnt    = r_cnt;
        if (push && !pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (pop && !push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_cnt    <= n_cnt;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= dec_tok;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/bqpost_back.sv =====
// back end: runs queued tokens against the operator stack, one pop per cycle while the output is not stalled
// depends on bqpost_pkg
`default_nettype none

module bqpost_back (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_q_valid,
    input  wire bqpost_pkg::t_tok          i_q_tok,
    output logic                           o_q_pop,
    output logic                           o_valid,
    input  wire logic                      i_stall,
    output logic [1:0]                     o_item_kind,
    output logic [15:0]                    o_item_word,
    output logic                           o_last_of_query,
    output logic                           o_stack_overflowed
);

    logic [1:0]                       r_stack [bqpost_pkg::STACK_DEPTH];
    logic [bqpost_pkg::CNT_W-1:0]     r_count, n_count;
    logic [bqpost_pkg::CNT_W-1:0]     r_op_count, n_op_count;
    logic                             r_ovf, n_ovf;
    logic                             r_out_valid;
    logic [1:0]                       r_out_kind;
    logic [15:0]                      r_out_word;
    logic                             r_out_last;
    logic                             r_out_ovf;

    logic [bqpost_pkg::CNT_W-1:0]     top_pos;
    logic [1:0]                       top;
    logic                             nonempty;
    logic                             full;
    logic                             out_free;
    logic                             want_push;
    logic [1:0]                       push_code;
    logic                             push_en;
    logic                             emit;
    logic [1:0]                       emit_kind;
    logic [15:0]                      emit_word;
    logic                             emit_last;

    // top of stack
    assign top_pos  = r_count - 1'b1;
    assign top      = r_stack[top_pos[bqpost_pkg::IDX_W-1:0]];
    assign nonempty = (r_count != '0);
    assign full     = (r_count == bqpost_pkg::CNT_W'(bqpost_pkg::STACK_DEPTH));
    assign out_free = !r_out_valid || !i_stall;

    // one step of the current token
    always_comb begin
        n_count    = r_count;
        n_op_count = r_op_count;
        n_ovf      = r_ovf;
        want_push  = 1'b0;
        push_code  = i_q_tok.code;
        emit       = 1'b0;
        emit_kind  = top;
        emit_word  = '0;
        emit_last  = 1'b0;
        o_q_pop    = 1'b0;
        if (i_q_valid) begin
            unique case (i_q_tok.cls)
                bqpost_pkg::CLS_WORD: begin
                    if (out_free) begin
                        emit      = 1'b1;
                        emit_kind = bqpost_pkg::CODE_WORD;
                        emit_word = i_q_tok.word;
                        o_q_pop   = 1'b1;
                    end
                end
                bqpost_pkg::CLS_OPEN: begin
                    want_push = 1'b1;
                    push_code = bqpost_pkg::CODE_OPEN;
                    o_q_pop   = 1'b1;
                end
                bqpost_pkg::CLS_CLOSE: begin
                    if (nonempty && top != bqpost_pkg::CODE_OPEN) begin
                        if (out_free) begin
                            emit       = 1'b1;
                            n_count    = r_count - 1'b1;
                            n_op_count = r_op_count - 1'b1;
                        end
                    end else begin
                        // drop the matching open parenthesis, if any
                        if (nonempty) begin
                            n_count = r_count - 1'b1;
                        end
                        o_q_pop = 1'b1;
                    end
                end
                bqpost_pkg::CLS_OPER: begin
                    if (nonempty && top != bqpost_pkg::CODE_OPEN && top >= i_q_tok.code) begin
                        if (out_free) begin
                            emit       = 1'b1;
                            n_count    = r_count - 1'b1;
                            n_op_count = r_op_count - 1'b1;
                        end
                    end else begin
                        want_push = 1'b1;
                        o_q_pop   = 1'b1;
                    end
                end
                bqpost_pkg::CLS_END: begin
                    if (nonempty) begin
                        if (top != bqpost_pkg::CODE_OPEN) begin
                            if (out_free) begin
                                emit       = 1'b1;
                                emit_last  = (r_op_count == bqpost_pkg::CNT_W'(1));
                                n_count    = r_count - 1'b1;
                                n_op_count = r_op_count - 1'b1;
                            end
                        end else begin
                            n_count = r_count - 1'b1;
                        end
                    end else begin
                        // query done: clear the sticky flag
                        n_ovf   = 1'b0;
                        o_q_pop = 1'b1;
                    end
                end
                default: begin
                    o_q_pop = 1'b1;
                end
            endcase
        end
        // push, or drop it on a full stack
        push_en = 1'b0;
        if (want_push) begin
            if (full) begin
                n_ovf = 1'b1;
            end else begin
                push_en = 1'b1;
                n_count = r_count + 1'b1;
                if (push_code != bqpost_pkg::CODE_OPEN) begin
                    n_op_count = r_op_count + 1'b1;
                end
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_op_count  <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count    <= n_count;
            r_op_count <= n_op_count;
            r_ovf      <= n_ovf;
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // stack storage and output register
    always_ff @(posedge i_clk) begin
        if (push_en) begin
            r_stack[r_count[bqpost_pkg::IDX_W-1:0]] <= push_code;
        end
        if (emit) begin
            r_out_kind <= emit_kind;
            r_out_word <= emit_word;
            r_out_last <= emit_last;
            r_out_ovf  <= r_ovf;
        end
    end

    assign o_valid            = r_out_valid;
    assign o_item_kind        = r_out_kind;
    assign o_item_word        = r_out_word;
    assign o_last_of_query    = r_out_last;
    assign o_stack_overflowed = r_out_ovf;

endmodule

`default_nettype wire

// ===== hdl/boolean_query_infix_to_postfix.sv =====
// Boolean query infix-to-postfix converter. Tokens (word, open, close, OR,
// AND, NOT, end) enter on the input channel and postfix items leave on the
// output channel, with a 16-entry operator stack (precedence OR<AND<NOT) in
// between. The front end takes one token per cycle into a four-entry queue
// while the queue is not full. The back end works through a token in steps:
// each step pops and emits one operator, the end marker also spends a step
// on every open parenthesis it discards, and a close parenthesis drops its
// open parenthesis in the step in which it leaves the queue. The token
// leaves the queue once no more operators are to be popped for it, and a
// step that emits waits while a result is held on a stalled output.
// A push onto a full stack is dropped and flagged on every item until the
// end marker, which flushes the stack and marks its last operator item.
// depends on bqpost_pkg, bqpost_front, bqpost_back
`default_nettype none

module boolean_query_infix_to_postfix (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_operation,
    input  wire logic [15:0] i_word_id,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [1:0]       o_item_kind,
    output logic [15:0]      o_item_word,
    output logic             o_last_of_query,
    output logic             o_stack_overflowed
);

    logic              q_valid;
    bqpost_pkg::t_tok  q_tok;
    logic              q_pop;

    // accept and decode
    bqpost_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_operation (i_operation),
        .i_word_id   (i_word_id),
        .o_q_valid   (q_valid),
        .o_q_tok     (q_tok),
        .i_q_pop     (q_pop)
    );

    // stack engine and output register
    bqpost_back u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .i_q_tok            (q_tok),
        .o_q_pop            (q_pop),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_item_kind        (o_item_kind),
        .o_item_word        (o_item_word),
        .o_last_of_query    (o_last_of_query),
        .o_stack_overflowed (o_stack_overflowed)
    );

endmodule

`default_nettype wire
